// File: hw/rtl/deque_with_search_macros.svh
// ----------------------------------------------------------------------------
// Deque assertion macros
// Concurrent assertion helpers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_SEARCH_MACROS_SVH
`define DEQUE_WITH_SEARCH_MACROS_SVH

`ifndef NO_ASSERTIONS

`define DEQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DEQ_ASSERT_IMPLY(lbl, ante, cons, msg)

`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: hw/rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// Deque package
// Request and status codes, cell shift operations and channel payload types.
// ----------------------------------------------------------------------------
package deq_pkg;

    // request codes
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_SEARCH     = 3'd4;
    localparam logic [2:0] REQ_READ       = 3'd5;
    localparam logic [2:0] REQ_CLEAR      = 3'd6;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_MISS  = 2'd3;

    // cell operations
    localparam logic [1:0] CELL_HOLD  = 2'd0;
    localparam logic [1:0] CELL_LEFT  = 2'd1;  // take from higher neighbor
    localparam logic [1:0] CELL_RIGHT = 2'd2;  // take from lower neighbor
    localparam logic [1:0] CELL_WRITE = 2'd3;  // addressed cell loads write data

    typedef struct packed {
        logic [1:0] op;
        logic       head_load;  // cell 0 takes write data on a right shift
    } deq_cell_ctl_t;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] data_in;
        logic [7:0]         index_in;
    } deq_req_t;

    typedef struct packed {
        logic signed [31:0] data_out;
        logic [7:0]         position;
        logic [1:0]         status;
        logic [8:0]         count_out;
    } deq_rsp_t;

endpackage

// File: hw/rtl/deq_stream_if.sv
// ----------------------------------------------------------------------------
// Deque stream channel
// Valid/ready channel carrying one payload struct per request.
// ----------------------------------------------------------------------------
interface deq_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/deque_with_search.sv
// Push front/back, pop front, clear and failed requests complete in the execute
// state. Read at index k, pop back and search (to a hit at position p, or over
// every element for a miss) rotate the cell ring to the target and back, one
// position a cycle. One request is in work at a time.
// Reset: asynchronous, active low; the queue comes up empty, cells uncleared.
// ----------------------------------------------------------------------------
// Deque with search, top level
// Bounded double-ended queue built as a ring of shifting cells.
// ----------------------------------------------------------------------------
module deque_with_search #(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    deq_stream_if.sink   req,
    deq_stream_if.source rsp
);
    import deq_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    deq_cell_ctl_t          cell_ctl;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic [VALUE_WIDTH-1:0] head;
    logic                   done;
    deq_rsp_t               rsp_data;
    logic                   out_free;
    logic                   req_ready;

    logic     rsp_valid_reg, rsp_valid_next;
    deq_rsp_t rsp_reg;

    assign out_free = !rsp_valid_reg || rsp.ready;

    deq_ctrl #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_data  (req.payload),
        .req_ready (req_ready),
        .out_free  (out_free),
        .done      (done),
        .rsp_data  (rsp_data),
        .cell_ctl  (cell_ctl),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .head      (head)
    );

    deq_chain #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW)
    ) u_chain (
        .clk      (clk),
        .cell_ctl (cell_ctl),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .head     (head)
    );

    // output register: a finished result waits here while the next request runs
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (done)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            rsp_reg <= rsp_data;
        end
    end

    assign req.ready   = req_ready;
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

endmodule

// File: hw/rtl/deq_cell.sv
// ----------------------------------------------------------------------------
// Deque cell
// One storage element of the chain: holds, shifts from a neighbor or loads.
// ----------------------------------------------------------------------------
module deq_cell #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  deq_pkg::deq_cell_ctl_t ctl,
    input  logic                   wr_hit,
    input  logic [VALUE_WIDTH-1:0] from_right,
    input  logic [VALUE_WIDTH-1:0] from_left,
    input  logic [VALUE_WIDTH-1:0] wr_data,
    output logic [VALUE_WIDTH-1:0] value
);
    import deq_pkg::*;

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        unique case (ctl.op)
            CELL_HOLD:  value_next = value_reg;
            CELL_LEFT:  value_next = from_right;
            CELL_RIGHT: value_next = from_left;
            CELL_WRITE: value_next = wr_hit ? wr_data : value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// File: hw/rtl/deq_chain.sv
// ----------------------------------------------------------------------------
// Deque cell chain
// Ring of cells; cell 0 always holds the element under the read head.
// ----------------------------------------------------------------------------
module deq_chain #(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32,
    parameter int AW          = $clog2(CAPACITY)
) (
    input  logic                   clk,
    input  deq_pkg::deq_cell_ctl_t cell_ctl,
    input  logic [AW-1:0]          wr_addr,
    input  logic [VALUE_WIDTH-1:0] wr_data,
    output logic [VALUE_WIDTH-1:0] head
);
    import deq_pkg::*;

    logic [VALUE_WIDTH-1:0] vals [CAPACITY];

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [VALUE_WIDTH-1:0] left_in;
            logic                   hit;

            if (i == 0)
            begin : g_head
                // push front feeds the new value in; a rotate wraps the last cell
                assign left_in = cell_ctl.head_load ? wr_data : vals[CAPACITY-1];
            end
            else
            begin : g_body
                assign left_in = vals[i-1];
            end

            assign hit = (wr_addr == AW'(i));

            deq_cell #(
                .VALUE_WIDTH(VALUE_WIDTH)
            ) u_cell (
                .clk        (clk),
                .ctl        (cell_ctl),
                .wr_hit     (hit),
                .from_right (vals[(i + 1) % CAPACITY]),
                .from_left  (left_in),
                .wr_data    (wr_data),
                .value      (vals[i])
            );
        end
    endgenerate

    assign head = vals[0];

endmodule

// File: hw/rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// Deque controller
// Sequences each request over the cell chain; scans rotate and then unwind.
// ----------------------------------------------------------------------------
`include "deque_with_search_macros.svh"

module deq_ctrl #(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32,
    parameter int AW          = $clog2(CAPACITY)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  deq_pkg::deq_req_t      req_data,
    output logic                   req_ready,
    input  logic                   out_free,
    output logic                   done,
    output deq_pkg::deq_rsp_t      rsp_data,
    output deq_pkg::deq_cell_ctl_t cell_ctl,
    output logic [AW-1:0]          wr_addr,
    output logic [VALUE_WIDTH-1:0] wr_data,
    input  logic [VALUE_WIDTH-1:0] head
);
    import deq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 8) ? CW : 8;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_REST = 2'd3;

    logic [1:0]             state_reg,  state_next;
    logic [CW-1:0]          count_reg,  count_next;
    logic [CW-1:0]          step_reg,   step_next;
    logic [CW-1:0]          tgt_reg,    tgt_next;
    logic [1:0]             status_reg, status_next;
    logic [VALUE_WIDTH-1:0] data_reg,   data_next;
    logic [CW-1:0]          pos_reg,    pos_next;
    logic [2:0]             op_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [7:0]             idx_reg;

    logic          full;
    logic          empty;
    logic          idx_oor;
    logic [XW-1:0] idx_x;

    assign full    = (count_reg == CW'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign idx_x   = XW'(idx_reg);
    assign idx_oor = (idx_x >= XW'(count_reg));

    assign req_ready = (state_reg == ST_IDLE);
    assign wr_addr   = count_reg[AW-1:0];
    assign wr_data   = val_reg;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        tgt_next    = tgt_reg;
        status_next = status_reg;
        data_next   = data_reg;
        pos_next    = pos_reg;
        cell_ctl    = '{op: CELL_HOLD, head_load: 1'b0};
        done        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                status_next = STAT_OK;
                data_next   = '0;
                pos_next    = '0;
                step_next   = '0;
                unique case (op_reg)
                    REQ_PUSH_FRONT:
                    begin
                        if (full)
                        begin
                            status_next = STAT_FULL;
                            done        = out_free;
                        end
                        else if (out_free)
                        begin
                            cell_ctl   = '{op: CELL_RIGHT, head_load: 1'b1};
                            count_next = count_reg + CW'(1);
                            done       = 1'b1;
                        end
                    end
                    REQ_PUSH_BACK:
                    begin
                        if (full)
                        begin
                            status_next = STAT_FULL;
                            done        = out_free;
                        end
                        else if (out_free)
                        begin
                            cell_ctl   = '{op: CELL_WRITE, head_load: 1'b0};
                            count_next = count_reg + CW'(1);
                            done       = 1'b1;
                        end
                    end
                    REQ_POP_FRONT:
                    begin
                        if (empty)
                        begin
                            status_next = STAT_EMPTY;
                            done        = out_free;
                        end
                        else if (out_free)
                        begin
                            data_next  = head;
                            cell_ctl   = '{op: CELL_LEFT, head_load: 1'b0};
                            count_next = count_reg - CW'(1);
                            done       = 1'b1;
                        end
                    end
                    REQ_POP_BACK:
                    begin
                        if (empty)
                        begin
                            status_next = STAT_EMPTY;
                            done        = out_free;
                        end
                        else
                        begin
                            tgt_next   = count_reg - CW'(1);
                            state_next = ST_SCAN;
                        end
                    end
                    REQ_SEARCH:
                    begin
                        if (empty)
                        begin
                            status_next = STAT_MISS;
                            done        = out_free;
                        end
                        else
                        begin
                            tgt_next   = count_reg - CW'(1);
                            state_next = ST_SCAN;
                        end
                    end
                    REQ_READ:
                    begin
                        if (idx_oor)
                        begin
                            status_next = STAT_MISS;
                            done        = out_free;
                        end
                        else
                        begin
                            tgt_next   = idx_x[CW-1:0];
                            state_next = ST_SCAN;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        if (out_free)
                        begin
                            count_next = '0;
                            done       = 1'b1;
                        end
                    end
                    default:
                    begin
                        done = out_free;
                    end
                endcase
            end
            ST_SCAN:
            begin
                // step_reg left rotations so far; head holds position step_reg
                if ((op_reg == REQ_SEARCH) && (head == val_reg))
                begin
                    pos_next   = step_reg;
                    state_next = ST_REST;
                end
                else if (step_reg == tgt_reg)
                begin
                    if (op_reg == REQ_SEARCH)
                    begin
                        status_next = STAT_MISS;
                    end
                    else
                    begin
                        data_next = head;
                    end
                    state_next = ST_REST;
                end
                else
                begin
                    cell_ctl  = '{op: CELL_LEFT, head_load: 1'b0};
                    step_next = step_reg + CW'(1);
                end
            end
            ST_REST:
            begin
                // unwind the scan rotations before finishing
                if (step_reg != '0)
                begin
                    cell_ctl  = '{op: CELL_RIGHT, head_load: 1'b0};
                    step_next = step_reg - CW'(1);
                end
                else if (out_free)
                begin
                    done = 1'b1;
                    if (op_reg == REQ_POP_BACK)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
        endcase

        if (done)
        begin
            state_next = ST_IDLE;
        end
    end

    always_comb
    begin
        rsp_data.data_out  = 32'(signed'(data_next));
        rsp_data.position  = 8'(pos_next);
        rsp_data.status    = status_next;
        rsp_data.count_out = 9'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            step_reg   <= '0;
            tgt_reg    <= '0;
            status_reg <= STAT_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            step_reg   <= step_next;
            tgt_reg    <= tgt_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        pos_reg  <= pos_next;
        if (req_valid && req_ready)
        begin
            op_reg  <= req_data.req_type;
            val_reg <= VALUE_WIDTH'(req_data.data_in);
            idx_reg <= req_data.index_in;
        end
    end

    `DEQ_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY), "count above capacity")
    `DEQ_ASSERT_IMPLY(a_scan_in_range, state_reg == ST_SCAN, step_reg <= tgt_reg && tgt_reg < count_reg, "scan beyond stored elements")
    `DEQ_ASSERT_NEXT(a_unwind_step, state_reg == ST_REST && step_reg != '0, step_reg == $past(step_reg) - CW'(1), "unwind step did not count down")
    `DEQ_ASSERT_NEXT(a_clear_empties, state_reg == ST_EXEC && op_reg == REQ_CLEAR && out_free, count_reg == '0, "clear left elements")

endmodule

// File: tb/deque_search_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deque response checker
// Watches both channels, predicts every response from its own copy of the
// ring store and pointers, and compares the responses against it in order.
// ----------------------------------------------------------------------------
module deque_search_checker #(
    parameter int CAPACITY = 256
) (
    input  logic   clk,
    input  logic   rst_n,
    deq_stream_if  req,
    deq_stream_if  rsp,
    output int     errors,
    output int     pending,
    output int     requests,
    output int     refused_pushes,
    output int     empty_pops,
    output int     search_hits
);
    import deq_pkg::*;

    logic signed [31:0] cells [CAPACITY];
    logic [7:0]         head;
    int                 depth;
    deq_rsp_t           awaited [$];

    // Applies one request to the shadow queue and returns its response.
    function automatic deq_rsp_t apply_request(deq_req_t r);
        deq_rsp_t res;
        res = '0;
        case (r.req_type)
            REQ_PUSH_FRONT:
                if (depth >= CAPACITY) res.status = STAT_FULL;
                else
                begin
                    head = head - 8'd1;
                    cells[head] = r.data_in;
                    depth++;
                end
            REQ_PUSH_BACK:
                if (depth >= CAPACITY) res.status = STAT_FULL;
                else
                begin
                    cells[head + 8'(depth)] = r.data_in;
                    depth++;
                end
            REQ_POP_FRONT:
                if (depth == 0) res.status = STAT_EMPTY;
                else
                begin
                    res.data_out = cells[head];
                    head = head + 8'd1;
                    depth--;
                end
            REQ_POP_BACK:
                if (depth == 0) res.status = STAT_EMPTY;
                else
                begin
                    res.data_out = cells[head + 8'(depth - 1)];
                    depth--;
                end
            REQ_SEARCH:
            begin
                res.status = STAT_MISS;
                for (int i = 0; i < depth; i++)
                begin
                    if (cells[head + 8'(i)] == r.data_in)
                    begin
                        res.status = STAT_OK;
                        res.position = 8'(i);
                        break;
                    end
                end
                if (res.status == STAT_OK) search_hits++;
            end
            REQ_READ:
                if (int'(r.index_in) >= depth) res.status = STAT_MISS;
                else res.data_out = cells[head + r.index_in];
            REQ_CLEAR:
            begin
                head = '0;
                depth = 0;
            end
            default: ;  // unused code: no effect
        endcase
        if (res.status == STAT_FULL) refused_pushes++;
        if (res.status == STAT_EMPTY) empty_pops++;
        res.count_out = 9'(depth);
        return res;
    endfunction

    always @(posedge clk)
    begin
        deq_rsp_t exp_rsp;
        deq_rsp_t got;
        if (!rst_n)
        begin
            awaited.delete();
            head = '0;
            depth = 0;
            pending <= 0;
        end
        else
        begin
            // a response can never belong to a request taken at this same edge
            if (rsp.valid && rsp.ready)
            begin
                got = rsp.payload;
                if (awaited.size() == 0)
                begin
                    $display("%0t: response with none pending: expected none, got data_out %0d",
                             $time, got.data_out);
                    errors++;
                end
                else
                begin
                    exp_rsp = awaited.pop_front();
                    if (got.data_out !== exp_rsp.data_out)
                    begin
                        $display("%0t: data_out expected %0d, got %0d",
                                 $time, exp_rsp.data_out, got.data_out);
                        errors++;
                    end
                    if (got.position !== exp_rsp.position)
                    begin
                        $display("%0t: position expected %0d, got %0d",
                                 $time, exp_rsp.position, got.position);
                        errors++;
                    end
                    if (got.status !== exp_rsp.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, exp_rsp.status, got.status);
                        errors++;
                    end
                    if (got.count_out !== exp_rsp.count_out)
                    begin
                        $display("%0t: count_out expected %0d, got %0d",
                                 $time, exp_rsp.count_out, got.count_out);
                        errors++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                awaited.push_back(apply_request(req.payload));
                requests++;
            end
            pending <= awaited.size();
        end
    end

endmodule

// File: tb/deque_with_search_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deque with search testbench
// Drives directed corner requests and then random traffic in fill, drain and
// mixed stretches, with random idling on both channels; the checker predicts
// and compares every response.
// ----------------------------------------------------------------------------
module deque_with_search_test;
    import deq_pkg::*;

    localparam logic [2:0] REQ_UNUSED = 3'd7;
    localparam int RANDOM_ITEMS = 1480;

    typedef enum int { SEG_MIXED, SEG_FILL, SEG_DRAIN } traffic_t;

    logic clk;
    logic rst_n;
    bit   steady;
    int   errors;
    int   pending;
    int   requests;
    int   refused_pushes;
    int   empty_pops;
    int   search_hits;

    logic signed [31:0] recent_values [$];

    deq_stream_if #(.payload_t(deq_req_t)) req_ch ();
    deq_stream_if #(.payload_t(deq_rsp_t)) rsp_ch ();

    deque_with_search dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    deque_search_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .errors         (errors),
        .pending        (pending),
        .requests       (requests),
        .refused_pushes (refused_pushes),
        .empty_pops     (empty_pops),
        .search_hits    (search_hits)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        rsp_ch.ready <= steady || ($urandom_range(99) >= 35);

    // Valid stays high after acceptance; the next call or the caller lowers it.
    task automatic send_request(input logic [2:0] kind, input logic signed [31:0] value,
                                input logic [7:0] index);
        deq_req_t item;
        item.req_type = kind;
        item.data_in  = value;
        item.index_in = index;
        while (!steady && $urandom_range(99) < 35)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= item;
        do @(posedge clk); while (!req_ch.ready);
        if (kind == REQ_PUSH_FRONT || kind == REQ_PUSH_BACK)
        begin
            recent_values.push_back(value);
            if (recent_values.size() > 32) void'(recent_values.pop_front());
        end
    endtask

    task automatic random_request(input traffic_t mode);
        int pick;
        int vpick;
        logic [2:0] kind;
        logic signed [31:0] value;
        logic [7:0] index;
        pick = $urandom_range(99);
        case (mode)
            SEG_FILL:
                kind = (pick < 90) ? ($urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT)
                     : (pick < 95) ? REQ_SEARCH : REQ_READ;
            SEG_DRAIN:
                kind = (pick < 90) ? ($urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT)
                     : (pick < 95) ? REQ_SEARCH : REQ_READ;
            default:
                kind = (pick < 3) ? REQ_UNUSED : 3'($urandom_range(6));
        endcase
        // searches mostly look for recently pushed values; pushes sometimes repeat
        // one so that the first match matters
        vpick = $urandom_range(99);
        if (recent_values.size() > 0 && vpick < ((kind == REQ_SEARCH) ? 70 : 10))
            value = recent_values[$urandom_range(recent_values.size() - 1)];
        else if (vpick < 90)
            value = $urandom;
        else
            case ($urandom_range(4))
                0: value = 32'sh8000_0000;
                1: value = 32'sh7fff_ffff;
                2: value = -32'sd1;
                3: value = 32'sd0;
                default: value = 32'sd1;
            endcase
        index = ($urandom_range(99) < 60) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
        send_request(kind, value, index);
    endtask

    initial
    begin
        int sent;
        int seg_len;
        int pick;
        traffic_t mode;
        clk            = 1'b0;
        rst_n          = 1'b0;
        steady         = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue failures
        send_request(REQ_POP_FRONT, 32'sd0, 8'd0);
        send_request(REQ_POP_BACK, 32'sd0, 8'd0);
        send_request(REQ_SEARCH, 32'sd0, 8'd0);
        send_request(REQ_READ, 32'sd0, 8'd0);
        // field extremes; push front wraps the front pointer below zero
        send_request(REQ_PUSH_FRONT, 32'sh8000_0000, 8'd0);
        send_request(REQ_PUSH_BACK, 32'sh7fff_ffff, 8'hff);
        send_request(REQ_PUSH_FRONT, -32'sd1, 8'd0);
        send_request(REQ_PUSH_BACK, 32'sd0, 8'd0);
        send_request(REQ_READ, 32'sd0, 8'd0);
        send_request(REQ_READ, 32'sd0, 8'd3);
        send_request(REQ_READ, 32'sd0, 8'd4);
        send_request(REQ_READ, -32'sd1, 8'd255);
        send_request(REQ_SEARCH, 32'sh7fff_ffff, 8'd0);
        send_request(REQ_SEARCH, 32'sd12345, 8'd0);
        send_request(REQ_UNUSED, -32'sd1, 8'hff);
        send_request(REQ_POP_BACK, 32'sd0, 8'd0);
        send_request(REQ_POP_FRONT, 32'sd0, 8'd0);
        send_request(REQ_CLEAR, 32'sd0, 8'd0);
        send_request(REQ_POP_FRONT, 32'sd0, 8'd0);
        send_request(REQ_PUSH_BACK, 32'sd5, 8'd0);
        send_request(REQ_POP_FRONT, 32'sd0, 8'd0);

        // first stretch fills past capacity, then the sender drains the pipe
        sent = 0;
        for (int k = 0; k < 320; k++)
        begin
            random_request(SEG_FILL);
            sent++;
        end
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);

        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            mode = (pick < 60) ? SEG_MIXED : (pick < 80) ? SEG_FILL : SEG_DRAIN;
            seg_len = (mode == SEG_MIXED) ? 40 : 280;
            for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++)
            begin
                steady <= (sent >= 400 && sent < 650);
                random_request(mode);
                sent++;
            end
        end
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d requests: %0d pushes refused when full, %0d pops on empty,",
                 requests, refused_pushes, empty_pops);
        $display("and %0d searches that found their value.", search_hits);
        if (errors == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
